### rtl/core/irm_pkg.sv
// Package for the inverter register map: codes, indices, beat types and
// the reset image of the register file. No dependencies.
`timescale 1ns / 1ps

package irm_pkg;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_REJ = 2'd2;

  localparam logic [15:0] CTRL_FIRST = 16'd154;
  localparam logic [16:0] CTRL_END = 17'd160;
  localparam int unsigned PCT_IDX = 155;
  localparam int unsigned ENA_IDX = 159;
  localparam logic [15:0] PCT_RESET = 16'd100;
  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [12:0] RATING_RESET = 13'd800;
  // ceil(2^23 / 10): exact divide by ten for products below 2^22
  localparam logic [19:0] DIV10_MUL = 20'd838861;
  localparam int unsigned DIV10_SHIFT = 23;
  localparam logic [15:0] NOT_IMPL_U = 16'hFFFF;
  localparam logic [15:0] NOT_IMPL_S = 16'h8000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] start_address;
    logic [15:0] word_count;
    logic [5:0][15:0] words;
    logic [15:0] demand_deciwatts;
    logic        demand_valid;
  } in_item_t;

  typedef struct packed {
    logic       ld_item;
    logic       mem_we;
    logic       rd_issue;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
    logic       mul0;
    logic       mul1;
    logic       lim_upd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rd_ok;
    logic       wr_ok;
    logic       ld_ok;
    logic       last;
    logic       out_busy;
    logic       out_taken;
  } dp_status_t;

  function automatic logic [15:0] irm_reset_word(input logic [7:0] idx);
    logic [15:0] w;
    case (idx)
      8'd0: w = 16'h5375;
      8'd1: w = 16'h6E53;
      8'd2: w = 16'd1;
      8'd3: w = 16'd66;
      8'd4: w = 16'h4563;
      8'd5: w = 16'h6F46;
      8'd6: w = 16'h6C6F;
      8'd7: w = 16'h7700;
      8'd20: w = 16'h506F;
      8'd21: w = 16'h7765;
      8'd22: w = 16'h7253;
      8'd23: w = 16'h7472;
      8'd24: w = 16'h6561;
      8'd25: w = 16'h6D00;
      8'd44: w = 16'h312E;
      8'd45: w = 16'h3000;
      8'd68: w = 16'd126;
      8'd70: w = 16'd101;
      8'd71: w = 16'd50;
      8'd122: w = 16'd120;
      8'd123: w = 16'd26;
      8'd124: w = 16'd4;
      8'd125: w = 16'd800;
      8'd127: w = 16'd800;
      8'd129, 8'd130, 8'd131, 8'd132: w = NOT_IMPL_S;
      8'd134: w = NOT_IMPL_U;
      8'd136, 8'd137, 8'd138, 8'd139: w = NOT_IMPL_S;
      8'd141, 8'd143, 8'd145, 8'd147: w = NOT_IMPL_U;
      8'd150: w = 16'd123;
      8'd151: w = 16'd24;
      8'd152, 8'd153: w = NOT_IMPL_U;
      8'd154: w = 16'd1;
      8'd155: w = PCT_RESET;
      8'd160: w = NOT_IMPL_S;
      8'd165, 8'd166, 8'd167: w = NOT_IMPL_S;
      8'd171: w = NOT_IMPL_U;
      8'd176: w = 16'hFFFF;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/irm_ifs.sv
// Channel interfaces of the inverter register map: transaction in,
// result out and rating write. No dependencies.
`timescale 1ns / 1ps

interface irm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] start_address;
  logic [15:0] word_count;
  logic [15:0] word_zero;
  logic [15:0] word_one;
  logic [15:0] word_two;
  logic [15:0] word_three;
  logic [15:0] word_four;
  logic [15:0] word_five;
  logic [15:0] demand_deciwatts;
  logic        demand_valid;
  modport source (output valid, opcode, start_address, word_count, word_zero, word_one,
                  word_two, word_three, word_four, word_five, demand_deciwatts,
                  demand_valid, input ready);
  modport sink (input valid, opcode, start_address, word_count, word_zero, word_one,
                word_two, word_three, word_four, word_five, demand_deciwatts,
                demand_valid, output ready);
endinterface

interface irm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] read_word;
  logic        last;
  logic        request_valid;
  logic [15:0] request_deciwatts;
  modport source (output valid, kind, read_word, last, request_valid, request_deciwatts,
                  input ready);
  modport sink (input valid, kind, read_word, last, request_valid, request_deciwatts,
                output ready);
endinterface

interface irm_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] rating_watts;
  modport source (output valid, rating_watts, input ready);
  modport sink (input valid, rating_watts, output ready);
endinterface

### rtl/core/irm_ctrl.sv
// Sequencer of the inverter register map: one transaction at a time.
// Depends on irm_pkg.
`timescale 1ns / 1ps

module irm_ctrl import irm_pkg::*; #(
  parameter int unsigned OFF_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dp_status_t       status_i,
  output ctrl_cmd_t        cmd_o,
  output logic [OFF_W-1:0] offset_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RD_ADDR = 4'd2;
  localparam logic [3:0] S_RD_DATA = 4'd3;
  localparam logic [3:0] S_RD_WAIT = 4'd4;
  localparam logic [3:0] S_WR = 4'd5;
  localparam logic [3:0] S_LIM0 = 4'd6;
  localparam logic [3:0] S_LIM1 = 4'd7;
  localparam logic [3:0] S_LIM2 = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [OFF_W-1:0] off_q, off_d;

  assign in_ready_o = (state_q == S_IDLE) && !status_i.out_busy;
  assign offset_o = off_q;

  always_comb begin
    state_d = state_q;
    off_d = off_q;
    cmd_o = '0;
    cmd_o.out_last = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.ld_item = 1'b1;
          off_d = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.op == OP_READ && status_i.rd_ok) begin
          state_d = S_RD_ADDR;
        end else if (status_i.op == OP_WRITE && status_i.wr_ok) begin
          state_d = S_WR;
        end else if (status_i.op == OP_LOAD && status_i.ld_ok) begin
          cmd_o.mem_we = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_ACK;
          state_d = S_IDLE;
        end else begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_REJ;
          state_d = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = KIND_DATA;
        cmd_o.out_last = status_i.last;
        state_d = status_i.last ? S_IDLE : S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (status_i.out_taken) begin
          off_d = off_q + 1'b1;
          state_d = S_RD_ADDR;
        end
      end
      S_WR: begin
        cmd_o.mem_we = 1'b1;
        if (status_i.last) begin
          state_d = S_LIM0;
        end else begin
          off_d = off_q + 1'b1;
        end
      end
      S_LIM0: begin
        cmd_o.mul0 = 1'b1;
        state_d = S_LIM1;
      end
      S_LIM1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_LIM2;
      end
      S_LIM2: begin
        cmd_o.lim_upd = 1'b1;
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = KIND_ACK;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      off_q <= '0;
    end else begin
      state_q <= state_d;
      off_q <= off_d;
    end
  end

endmodule

### rtl/core/irm_datapath.sv
// Datapath of the inverter register map: register file, limit logic,
// request arithmetic and result register. Depends on irm_pkg.
`timescale 1ns / 1ps

module irm_datapath import irm_pkg::*; #(
  parameter int unsigned NUM_REGS = 178,
  parameter int unsigned MAX_READ = 64,
  parameter int unsigned OFF_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         item_i,
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_rating_i,
  input  ctrl_cmd_t        cmd_i,
  input  logic [OFF_W-1:0] offset_i,
  output dp_status_t       status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [15:0]      out_word_o,
  output logic             out_last_o,
  output logic             out_req_valid_o,
  output logic [15:0]      out_req_dw_o
);

  localparam int unsigned ADDR_W = $clog2(NUM_REGS);

  in_item_t          item_q;
  logic [12:0]       rating_q;
  logic [15:0]       mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [15:0]       mem_rd_q, img_rd_q;
  logic              vld_rd_q;
  logic [15:0]       pct_q;
  logic              ena_q;
  logic              lim_act_q, base_known_q;
  logic [15:0]       base_q;
  logic [19:0]       prod_q;
  logic [16:0]       quot_q;
  logic [39:0]       recip;
  logic [6:0]        pct_clamp;
  logic [ADDR_W-1:0] addr;
  logic [15:0]       wdata;
  logic [16:0]       end_addr;
  logic              req_v;
  logic [15:0]       req_dw;
  logic              out_valid_q, out_last_q, out_rv_q;
  logic [1:0]        out_kind_q;
  logic [15:0]       out_word_q, out_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rating_q <= RATING_RESET;
    end else if (cfg_we_i) begin
      rating_q <= cfg_rating_i;
    end
  end

  assign addr = item_q.start_address[ADDR_W-1:0] + ADDR_W'(offset_i);
  assign end_addr = {1'b0, item_q.start_address} + {1'b0, item_q.word_count};

  always_comb begin
    case (offset_i[2:0])
      3'd0: wdata = item_q.words[0];
      3'd1: wdata = item_q.words[1];
      3'd2: wdata = item_q.words[2];
      3'd3: wdata = item_q.words[3];
      3'd4: wdata = item_q.words[4];
      default: wdata = item_q.words[5];
    endcase
  end

  always_comb begin
    status_o.op = item_q.opcode;
    status_o.rd_ok = (item_q.word_count != 16'd0) && (item_q.word_count <= 16'(MAX_READ))
                     && (end_addr <= 17'(NUM_REGS));
    status_o.wr_ok = (item_q.word_count != 16'd0) && (item_q.start_address >= CTRL_FIRST)
                     && (end_addr <= CTRL_END);
    status_o.ld_ok = item_q.start_address < 16'(NUM_REGS);
    status_o.last = (16'(offset_i) + 16'd1) == item_q.word_count;
    status_o.out_busy = out_valid_q;
    status_o.out_taken = out_valid_q && out_ready_i;
  end

  // register file: entries not yet written read back from the reset image
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.rd_issue) begin
      mem_rd_q <= mem[addr];
      vld_rd_q <= vld_q[addr];
      img_rd_q <= irm_reset_word(8'(addr));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      pct_q <= PCT_RESET;
      ena_q <= 1'b0;
    end else if (cmd_i.mem_we) begin
      vld_q[addr] <= 1'b1;
      if (addr == ADDR_W'(PCT_IDX)) begin
        pct_q <= wdata;
      end
      if (addr == ADDR_W'(ENA_IDX)) begin
        ena_q <= wdata == 16'd1;
      end
    end
  end

  assign pct_clamp = (pct_q > 16'(PCT_MAX)) ? PCT_MAX : pct_q[6:0];
  assign recip = 40'(prod_q) * 40'(DIV10_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul0) begin
      prod_q <= 20'(pct_clamp) * 20'(rating_q);
    end
    if (cmd_i.mul1) begin
      quot_q <= recip[DIV10_SHIFT +: 17];
    end
  end

  always_comb begin
    req_v = 1'b0;
    req_dw = 16'd0;
    if (ena_q) begin
      req_v = 1'b1;
      req_dw = quot_q[16] ? 16'hFFFF : quot_q[15:0];
    end else if (lim_act_q && base_known_q) begin
      req_v = 1'b1;
      req_dw = base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_act_q <= 1'b0;
      base_known_q <= 1'b0;
      base_q <= 16'd0;
    end else if (cmd_i.lim_upd) begin
      lim_act_q <= ena_q;
      if (ena_q && !lim_act_q) begin
        base_known_q <= item_q.demand_valid;
        base_q <= item_q.demand_valid ? item_q.demand_deciwatts : 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_last_q <= cmd_i.out_last;
      out_word_q <= (cmd_i.out_kind == KIND_DATA) ? (vld_rd_q ? mem_rd_q : img_rd_q) : 16'd0;
      out_rv_q <= cmd_i.lim_upd && req_v;
      out_rd_q <= cmd_i.lim_upd ? req_dw : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o = out_kind_q;
  assign out_word_o = out_word_q;
  assign out_last_o = out_last_q;
  assign out_req_valid_o = out_rv_q;
  assign out_req_dw_o = out_rd_q;

endmodule

### rtl/core/inverter_register_map_with_limit.sv
// Top level of the inverter register map with power-limit control.
// Depends on irm_pkg, irm_ifs, irm_ctrl and irm_datapath.
`timescale 1ns / 1ps

// Takes one transaction beat at a time and holds the next off until every
// result of the current one has left the result register. For a read, the
// single-port register file gives one registered read per word, and the next
// read starts after the result register has handed on its beat. A write does
// one file write per word, then a multiply, a divide-by-ten multiply and the
// limit update; a load or a reject is answered straight from decode. The
// register file comes out of reset at once with its identification image;
// there is no clearing pass. The rating register may be written at any time
// the block is idle.
module inverter_register_map_with_limit import irm_pkg::*; #(
  parameter int unsigned NUM_REGS = 178,
  parameter int unsigned MAX_READ = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  irm_in_if.sink   in_i,
  irm_out_if.source out_o,
  irm_cfg_if.sink  cfg_i
);

  localparam int unsigned OFF_W = ($clog2(MAX_READ) > 3) ? $clog2(MAX_READ) : 3;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [OFF_W-1:0] offset;
  in_item_t         item;

  assign item.opcode = in_i.opcode;
  assign item.start_address = in_i.start_address;
  assign item.word_count = in_i.word_count;
  assign item.words = {in_i.word_five, in_i.word_four, in_i.word_three,
                       in_i.word_two, in_i.word_one, in_i.word_zero};
  assign item.demand_deciwatts = in_i.demand_deciwatts;
  assign item.demand_valid = in_i.demand_valid;

  assign cfg_i.ready = 1'b1;

  irm_ctrl #(
    .OFF_W(OFF_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .status_i  (status),
    .cmd_o     (cmd),
    .offset_o  (offset)
  );

  irm_datapath #(
    .NUM_REGS(NUM_REGS),
    .MAX_READ(MAX_READ),
    .OFF_W   (OFF_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .cfg_we_i       (cfg_i.valid),
    .cfg_rating_i   (cfg_i.rating_watts),
    .cmd_i          (cmd),
    .offset_i       (offset),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_kind_o     (out_o.kind),
    .out_word_o     (out_o.read_word),
    .out_last_o     (out_o.last),
    .out_req_valid_o(out_o.request_valid),
    .out_req_dw_o   (out_o.request_deciwatts)
  );

`ifndef ASSERT_OFF
  a_in_only_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !out_o.valid)
    else $error("transaction beat taken while a result beat is pending");

  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KIND_DATA) |-> out_o.last)
    else $error("accept or reject beat without last");

  a_request_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.request_valid) |-> (out_o.kind == KIND_ACK))
    else $error("power request on a beat that is not an accept");

  a_request_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.request_valid) |-> (out_o.request_deciwatts == 16'd0))
    else $error("request value without request");
`endif

endmodule
